[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the chaser checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DLC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("dlc assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define DLC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("dlc assertion failed");

`endif

[hw/rtl/dlc_pkg.sv]
// ----------------------------------------------------------------------------
// dlc_pkg
// Types and constants shared by the debounced LED chaser modules.
// ----------------------------------------------------------------------------
package dlc_pkg;

	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_DELAY = 1'b1;

	localparam logic [9:0] STEP_PERIOD_RST  = 10'd100;
	localparam logic [7:0] BOUNCE_DELAY_RST = 8'd2;
	localparam logic [9:0] PERIOD_COUNT_RST = 10'd2;

	typedef enum logic [2:0] {
		PH_OPEN   = 3'b001,
		PH_CLOSED = 3'b010,
		PH_BOUNCE = 3'b100
	} db_phase_t;

	// One result transfer, packed so that led_pattern sits in the lowest bits.
	typedef struct packed {
		logic       inverted;
		logic       reverse_dir;
		logic [2:0] led_position;
		logic [4:0] led_pattern;
	} chase_res_t;

endpackage

[hw/rtl/dlc_debounce.sv]
// ----------------------------------------------------------------------------
// dlc_debounce
// Three-phase debouncer for button one; flags a press on open to closed.
// ----------------------------------------------------------------------------
module dlc_debounce (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       level,
	input  logic [7:0] bounce_delay,
	output logic       press
);
	import dlc_pkg::*;

	db_phase_t  phase_q, phase_d;
	logic [7:0] count_q, count_d, count_dec;

	always_comb begin
		count_dec = (count_q != 8'd0) ? count_q - 8'd1 : 8'd0;
		phase_d   = phase_q;
		count_d   = count_dec;
		press     = 1'b0;
		unique case (phase_q)
			PH_CLOSED: begin
				if (!level) begin
					phase_d = PH_BOUNCE;
					count_d = bounce_delay;
				end
			end
			PH_BOUNCE: begin
				if (level) begin
					phase_d = PH_CLOSED;
				end else if (count_dec == 8'd0) begin
					phase_d = PH_OPEN;
				end
			end
			default: begin
				// Open, and any code that is not a legal phase.
				if (level) begin
					phase_d = PH_CLOSED;
					press   = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			count_q <= 8'd0;
		end else if (en) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

endmodule

[hw/rtl/dlc_chaser.sv]
// ----------------------------------------------------------------------------
// dlc_chaser
// Pending-event flags, mode bits and the stepping LED position and pattern.
// ----------------------------------------------------------------------------
module dlc_chaser #(
	parameter int NUM_LEDS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               press,
	input  logic               b5_event,
	input  logic [9:0]         step_period,
	output dlc_pkg::chase_res_t res
);
	import dlc_pkg::*;

	localparam int POS_W = $clog2(NUM_LEDS);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_LEDS - 1);

	logic                b1_pend_q, b1_pend_d, b5_pend_q, b5_pend_d;
	logic                b1p, b5p;
	logic                rev_q, rev_d, inv_q, inv_d;
	logic [9:0]          period_q, period_d, period_dec;
	logic [POS_W-1:0]    pos_q, pos_d, pos_next;
	logic                pos_valid_q, pos_valid_d;
	logic [NUM_LEDS-1:0] pattern_q, pattern_d, mark;
	logic [31:0]         pat_ext;
	logic [7:0]          pos_ext;

	always_comb begin
		if (rev_q) begin
			pos_next = (!pos_valid_q || pos_q == '0) ? LAST_POS : pos_q - POS_W'(1);
		end else begin
			pos_next = (!pos_valid_q || pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
		end
		mark = NUM_LEDS'(1) << pos_next;
	end

	always_comb begin
		b5p         = b5_pend_q | b5_event;
		b1p         = b1_pend_q | press;
		period_dec  = (period_q != 10'd0) ? period_q - 10'd1 : 10'd0;
		b5_pend_d   = b5p;
		b1_pend_d   = b1p;
		rev_d       = rev_q;
		inv_d       = inv_q;
		period_d    = period_dec;
		pos_d       = pos_q;
		pos_valid_d = pos_valid_q;
		pattern_d   = pattern_q;
		// Only one action per tick: invert, then reverse, then advance.
		if (b5p) begin
			inv_d     = ~inv_q;
			b5_pend_d = 1'b0;
		end else if (b1p) begin
			rev_d     = ~rev_q;
			b1_pend_d = 1'b0;
		end else if (period_dec == 10'd0) begin
			pos_d       = pos_next;
			pos_valid_d = 1'b1;
			pattern_d   = inv_q ? ~mark : mark;
			period_d    = step_period;
		end
	end

	always_comb begin
		pat_ext          = 32'(pattern_d);
		pos_ext          = 8'(pos_d);
		res.led_pattern  = pat_ext[4:0];
		res.led_position = pos_ext[2:0];
		res.reverse_dir  = rev_d;
		res.inverted     = inv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_pend_q   <= 1'b0;
			b5_pend_q   <= 1'b0;
			rev_q       <= 1'b0;
			inv_q       <= 1'b0;
			period_q    <= PERIOD_COUNT_RST;
			pos_q       <= '0;
			pos_valid_q <= 1'b0;
			pattern_q   <= '0;
		end else if (en) begin
			b1_pend_q   <= b1_pend_d;
			b5_pend_q   <= b5_pend_d;
			rev_q       <= rev_d;
			inv_q       <= inv_d;
			period_q    <= period_d;
			pos_q       <= pos_d;
			pos_valid_q <= pos_valid_d;
			pattern_q   <= pattern_d;
		end
	end

endmodule

[hw/rtl/debounced_led_chaser_core.sv]
// ----------------------------------------------------------------------------
// debounced_led_chaser_core
// LED chaser steered by a debounced button and a pulsed button, per tick.
// ----------------------------------------------------------------------------
// Usage: send one transfer on the s_ channel per 10 ms tick, carrying the raw
// level of button one and the button-five pulse. Every tick transfer yields
// exactly one result transfer on the m_ channel with the LED pattern, the
// marked position and the direction and inversion flags.
// The user is to write the two registers (step period, bounce delay) on the cfg
// port only while no tick is in flight; the core does not enforce this. A write
// takes effect at the next clock edge. A tick is captured in the input register;
// then the debouncer and chaser update their state and load the result register,
// whose m_tvalid rises in the same edge. Throughput is one tick per cycle while
// the receiver does not stall, set by the single pass of logic between the input
// register and the result register. When the receiver stalls, the result
// register holds its data and the input register takes one more tick if it
// is empty; s_tready then drops until the result moves.
// Reset clears the pending events, the debouncer, the mode bits and both
// channel valids, sets the period counter to two and the registers to their
// defaults (step period 100, bounce delay 2).
// ----------------------------------------------------------------------------
module debounced_led_chaser_core #(
	parameter int NUM_LEDS = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [0] b1_level, [1] b5_event, [7:2] zero
	input  logic [dlc_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [4:0] led_pattern, [7:5] led_position, [8] reverse_dir, [9] inverted,
	// [15:10] zero
	output logic [dlc_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             cfg_we,
	input  logic [dlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dlc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dlc_pkg::*;

	logic       step_en;
	logic       in_valid_s1, b1_s1, b5_s1;
	logic       out_valid_s2;
	chase_res_t result_s2, res;
	logic       press;
	logic [9:0] step_period_q;
	logic [7:0] bounce_delay_q;

	assign step_en  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || step_en;
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {6'b0, result_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q  <= STEP_PERIOD_RST;
			bounce_delay_q <= BOUNCE_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_PERIOD:  step_period_q  <= cfg_data;
				REG_BOUNCE_DELAY: bounce_delay_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			b1_s1 <= s_tdata[0];
			b5_s1 <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step_en) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_s2 <= res;
		end
	end

	dlc_debounce u_debounce (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (step_en),
		.level        (b1_s1),
		.bounce_delay (bounce_delay_q),
		.press        (press)
	);

	dlc_chaser #(
		.NUM_LEDS (NUM_LEDS)
	) u_chaser (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (step_en),
		.press       (press),
		.b5_event    (b5_s1),
		.step_period (step_period_q),
		.res         (res)
	);

endmodule

[hw/rtl/dlc_checker.sv]
// ----------------------------------------------------------------------------
// dlc_checker
// Port-level checks on the chaser core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result keeps its data until it is taken.
	`DLC_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// With the result stalled, the core buffers one tick and then blocks until the result moves.
	`DLC_ASSERT(a_one_slot, clk, arst_n, m_tvalid && !m_tready && s_tvalid && s_tready |=> !s_tready || m_tready)

	// The pattern marks at most one LED, either lit among dark ones or dark among lit ones.
	`DLC_ASSERT(a_one_marked, clk, arst_n, m_tvalid |-> $onehot0(m_tdata[4:0]) || $onehot(~m_tdata[4:0]))

	// Reset clears the result valid by the next edge.
	`DLC_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !m_tvalid)

endmodule

bind debounced_led_chaser_core dlc_checker u_dlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
